>>> hw/rtl/resf_pkg.sv
// Shared types, constants and fixed-point helpers for the rod edge stretch force unit.
package resf_pkg;

    localparam int DIV_N_W     = 48;
    localparam int DIV_D_W     = 31;
    localparam int DIV_STEPS   = DIV_N_W;
    localparam int PIPE_STAGES = 15;
    localparam int VLD_LEN     = 1 + DIV_STEPS + PIPE_STAGES;
    localparam int CFG_IDX_W   = 2;
    localparam int S_DATA_W    = 224;
    localparam int M_DATA_W    = 320;

    localparam logic [CFG_IDX_W-1:0] REG_ELASTIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;

    typedef logic signed [63:0] q_t;

    localparam q_t ONE_Q    = 64'sd65536;
    localparam q_t HALF_Q   = 64'sd32768;
    localparam q_t PI_Q     = 64'sd205887;
    localparam q_t WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    typedef struct packed {
        logic [63:0] p0;
        logic [63:0] p1;
        logic [63:0] p2;
        logic [63:0] p3;
        logic        neg;
    } pp_t;

    typedef struct packed {
        q_t   val;
        logic flt;
    } qres_t;

    typedef struct packed {
        logic [31:0] val;
        logic        flt;
    } o32_t;

    typedef struct packed {
        logic [31:0] modulus;
        logic [30:0] r0;
        logic [30:0] r1;
        logic [30:0] rest;
        logic        zero;
        logic [2:0]  neg;
    } side_t;

    typedef struct packed {
        q_t          modulus;
        q_t          r0;
        q_t          r1;
        q_t          rest;
        q_t          s;
        q_t          inv_len;
        q_t          d;
        q_t          ks;
        q_t          eh;
        q_t          v;
        q_t [2:0]    t;
        q_t [5:0]    tt;
        q_t [2:0]    f;
        q_t [5:0]    cp;
        pp_t [7:0]   pp;
        logic        zero;
        logic        flt;
    } item_t;

    function automatic logic [63:0] mag64(q_t a);
        mag64 = a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic pp_t qmul_pp(q_t a, q_t b);
        logic [63:0] x;
        logic [63:0] y;
        pp_t         p;
        x     = mag64(a);
        y     = mag64(b);
        p.p0  = {32'b0, x[31:0]} * {32'b0, y[31:0]};
        p.p1  = {32'b0, x[31:0]} * {32'b0, y[63:32]};
        p.p2  = {32'b0, x[63:32]} * {32'b0, y[31:0]};
        p.p3  = {32'b0, x[63:32]} * {32'b0, y[63:32]};
        p.neg = a[63] ^ b[63];
        return p;
    endfunction

    function automatic qres_t qmul_fin(pp_t p);
        logic [63:0] mid;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] lo2;
        logic [63:0] r;
        logic        cy;
        qres_t       res;
        mid = {32'b0, p.p0[63:32]} + {32'b0, p.p1[31:0]} + {32'b0, p.p2[31:0]};
        lo  = {mid[31:0], p.p0[31:0]};
        hi  = p.p3 + {32'b0, p.p1[63:32]} + {32'b0, p.p2[63:32]} + {32'b0, mid[63:32]};
        {cy, lo2} = {1'b0, lo} + 65'h8000;
        hi  = hi + {63'b0, cy};
        res.flt = 1'b0;
        if (hi[63:16] != 48'b0) begin
            r       = 64'(WIDE_MAX);
            res.flt = 1'b1;
        end else begin
            r = {hi[15:0], lo2[63:16]};
            if (r > 64'(WIDE_MAX)) begin
                r       = 64'(WIDE_MAX);
                res.flt = 1'b1;
            end
        end
        res.val = p.neg ? -q_t'(r) : q_t'(r);
        return res;
    endfunction

    function automatic qres_t bound_add(q_t a, q_t b);
        q_t    sum;
        qres_t res;
        sum     = a + b;
        res.val = sum;
        res.flt = 1'b0;
        if (sum > WIDE_MAX) begin
            res.val = WIDE_MAX;
            res.flt = 1'b1;
        end else if (sum < -WIDE_MAX) begin
            res.val = -WIDE_MAX;
            res.flt = 1'b1;
        end
        return res;
    endfunction

    function automatic o32_t clamp32(q_t a);
        o32_t res;
        res.val = a[31:0];
        res.flt = 1'b0;
        if (a > 64'sd2147483647) begin
            res.val = 32'h7FFF_FFFF;
            res.flt = 1'b1;
        end else if (a < -64'sd2147483648) begin
            res.val = 32'h8000_0000;
            res.flt = 1'b1;
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/resf_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
module resf_divider (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [resf_pkg::DIV_N_W-1:0]  numer,
    input  logic [resf_pkg::DIV_D_W-1:0]  denom,
    output logic [resf_pkg::DIV_N_W-1:0]  quot
);
    import resf_pkg::*;

    logic [DIV_D_W-1:0] rem_reg  [DIV_STEPS];
    logic [DIV_N_W-1:0] nq_reg   [DIV_STEPS];
    logic [DIV_D_W-1:0] dv_reg   [DIV_STEPS];
    logic [DIV_D_W-1:0] rem_next [DIV_STEPS];
    logic [DIV_N_W-1:0] nq_next  [DIV_STEPS];
    logic [DIV_D_W-1:0] dv_next  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_D_W-1:0] src_rem;
        logic [DIV_N_W-1:0] src_nq;
        logic [DIV_D_W-1:0] src_dv;
        logic [DIV_D_W:0]   cand;
        logic               ge;

        if (k == 0) begin : g_first
            assign src_rem = '0;
            assign src_nq  = numer;
            assign src_dv  = denom;
        end else begin : g_rest
            assign src_rem = rem_reg[k-1];
            assign src_nq  = nq_reg[k-1];
            assign src_dv  = dv_reg[k-1];
        end

        always_comb begin
            cand        = {src_rem, src_nq[DIV_N_W-1]};
            ge          = (cand >= {1'b0, src_dv});
            rem_next[k] = ge ? DIV_D_W'(cand - {1'b0, src_dv}) : cand[DIV_D_W-1:0];
            nq_next[k]  = {src_nq[DIV_N_W-2:0], ge};
            dv_next[k]  = src_dv;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                dv_reg[k]  <= dv_next[k];
            end
        end
    end

    assign quot = nq_reg[DIV_STEPS-1];

endmodule

>>> hw/rtl/rod_edge_stretch_force_unit.sv
// Top level of the rod edge stretch force unit: dividers, multiply pipeline, output register.
//
//  channel | ports          | direction | contents
//  --------+----------------+-----------+-------------------------------------------
//  input   | s_axis_*       | in        | edge vector, length, radii, rest, mode
//  result  | m_axis_*       | out       | energy, force, coupling block, fault flag
//  config  | cfg_*          | in        | modulus register writes
//
// One request enters per cycle while the result channel is not stalled.
// The pipeline includes the 48-step divider pipeline and seven two-stage multiplies.
// Reset clears all valid bits and loads the modulus registers with their defaults.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module rod_edge_stretch_force_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // edge_x, edge_y, edge_z, edge_length, radius_major, radius_minor, rest_length, zero pad
    input  logic [resf_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // use_viscous
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // stretch_energy, force_x, force_y, force_z, coupling_xx, coupling_xy,
    // coupling_xz, coupling_yy, coupling_yz, coupling_zz
    output logic [resf_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // range_fault
    output logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [resf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import resf_pkg::*;

    logic                  en;
    logic [31:0]           elastic_reg;
    logic [31:0]           damping_reg;
    logic [VLD_LEN-1:0]    vld_reg;
    logic [VLD_LEN-1:0]    vld_next;
    logic [31:0]           ex_reg, ey_reg, ez_reg;
    logic [30:0]           len_reg, r0_reg, r1_reg, rest_reg;
    logic                  visc_reg;
    side_t                 side_in;
    side_t                 side_reg [DIV_STEPS];
    logic [DIV_N_W-1:0]    numer [6];
    logic [DIV_D_W-1:0]    denom [6];
    logic [DIV_N_W-1:0]    quot  [6];
    item_t                 pipe_reg  [PIPE_STAGES];
    item_t                 pipe_next [PIPE_STAGES];
    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_DATA_W-1:0]   m_data_next;
    logic                  m_fault_reg;
    logic                  m_fault_next;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elastic_reg <= 32'h0001_0000;
            damping_reg <= 32'h0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ELASTIC: elastic_reg <= cfg_data;
                REG_DAMPING: damping_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign vld_next = {vld_reg[VLD_LEN-2:0], s_axis_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= vld_next;
            m_valid_reg <= vld_reg[VLD_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg   <= s_axis_tdata[31:0];
            ey_reg   <= s_axis_tdata[63:32];
            ez_reg   <= s_axis_tdata[95:64];
            len_reg  <= s_axis_tdata[126:96];
            r0_reg   <= s_axis_tdata[157:127];
            r1_reg   <= s_axis_tdata[188:158];
            rest_reg <= s_axis_tdata[219:189];
            visc_reg <= s_axis_tuser;
        end
    end

    always_comb begin
        side_in.modulus = visc_reg ? damping_reg : elastic_reg;
        side_in.r0      = r0_reg;
        side_in.r1      = r1_reg;
        side_in.rest    = rest_reg;
        side_in.zero    = (len_reg == 31'b0) || (rest_reg == 31'b0);
        side_in.neg     = {ez_reg[31], ey_reg[31], ex_reg[31]};
        numer[0] = {ex_reg[31] ? 32'(-ex_reg) : ex_reg, 16'b0} + {17'b0, len_reg[30:1]};
        numer[1] = {ey_reg[31] ? 32'(-ey_reg) : ey_reg, 16'b0} + {17'b0, len_reg[30:1]};
        numer[2] = {ez_reg[31] ? 32'(-ez_reg) : ez_reg, 16'b0} + {17'b0, len_reg[30:1]};
        numer[3] = {1'b0, len_reg, 16'b0} + {17'b0, rest_reg[30:1]};
        numer[4] = 48'h1_0000_0000 + {17'b0, len_reg[30:1]};
        numer[5] = 48'h1_0000_0000 + {17'b0, rest_reg[30:1]};
        denom[0] = len_reg;
        denom[1] = len_reg;
        denom[2] = len_reg;
        denom[3] = rest_reg;
        denom[4] = len_reg;
        denom[5] = rest_reg;
    end

    for (genvar k = 0; k < 6; k++) begin : g_div
        resf_divider u_div (
            .aclk  (aclk),
            .en    (en),
            .numer (numer[k]),
            .denom (denom[k]),
            .quot  (quot[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb begin
        qres_t qr;
        side_t sd;
        sd = side_reg[DIV_STEPS-1];

        pipe_next[0]         = '0;
        pipe_next[0].modulus = q_t'({32'b0, sd.modulus});
        pipe_next[0].r0      = q_t'({33'b0, sd.r0});
        pipe_next[0].r1      = q_t'({33'b0, sd.r1});
        pipe_next[0].rest    = q_t'({33'b0, sd.rest});
        pipe_next[0].zero    = sd.zero;
        for (int i = 0; i < 3; i++) begin
            pipe_next[0].t[i] = sd.neg[i] ? -q_t'({16'b0, quot[i]}) : q_t'({16'b0, quot[i]});
        end
        pipe_next[0].s       = q_t'({16'b0, quot[3]}) - ONE_Q;
        pipe_next[0].inv_len = q_t'({16'b0, quot[4]});
        pipe_next[0].d       = q_t'({16'b0, quot[5]}) - q_t'({16'b0, quot[4]});

        pipe_next[1] = pipe_reg[0];
        pipe_next[1].pp[0] = qmul_pp(pipe_reg[0].modulus, PI_Q);
        for (int k = 0; k < 6; k++) begin
            pipe_next[1].pp[k+1] = qmul_pp(pipe_reg[0].t[PAIR_I[k]], pipe_reg[0].t[PAIR_J[k]]);
        end

        pipe_next[2] = pipe_reg[1];
        qr = qmul_fin(pipe_reg[1].pp[0]);
        pipe_next[2].ks  = qr.val;
        pipe_next[2].flt = pipe_reg[1].flt | qr.flt;
        for (int k = 0; k < 6; k++) begin
            qr = qmul_fin(pipe_reg[1].pp[k+1]);
            pipe_next[2].tt[k] = qr.val;
            pipe_next[2].flt   = pipe_next[2].flt | qr.flt;
        end

        pipe_next[3] = pipe_reg[2];
        pipe_next[3].pp[0] = qmul_pp(pipe_reg[2].ks, pipe_reg[2].r0);
        for (int k = 0; k < 6; k++) begin
            pipe_next[3].pp[k+1] = qmul_pp(pipe_reg[2].tt[k], pipe_reg[2].inv_len);
        end

        pipe_next[4] = pipe_reg[3];
        qr = qmul_fin(pipe_reg[3].pp[0]);
        pipe_next[4].ks  = qr.val;
        pipe_next[4].flt = pipe_reg[3].flt | qr.flt;
        for (int k = 0; k < 6; k++) begin
            qr = qmul_fin(pipe_reg[3].pp[k+1]);
            pipe_next[4].tt[k] = qr.val;
            pipe_next[4].flt   = pipe_next[4].flt | qr.flt;
        end

        pipe_next[5] = pipe_reg[4];
        pipe_next[5].pp[0] = qmul_pp(pipe_reg[4].ks, pipe_reg[4].r1);
        for (int k = 0; k < 6; k++) begin
            if (PAIR_I[k] == PAIR_J[k]) begin
                qr = bound_add(pipe_reg[4].tt[k], pipe_reg[4].d);
                pipe_next[5].tt[k] = qr.val;
                pipe_next[5].flt   = pipe_next[5].flt | qr.flt;
            end
        end

        pipe_next[6] = pipe_reg[5];
        qr = qmul_fin(pipe_reg[5].pp[0]);
        pipe_next[6].ks  = qr.val;
        pipe_next[6].flt = pipe_reg[5].flt | qr.flt;

        pipe_next[7] = pipe_reg[6];
        pipe_next[7].pp[0] = qmul_pp(pipe_reg[6].ks, HALF_Q);
        pipe_next[7].pp[1] = qmul_pp(pipe_reg[6].ks, pipe_reg[6].s);
        for (int k = 0; k < 6; k++) begin
            pipe_next[7].pp[k+2] = qmul_pp(pipe_reg[6].ks, pipe_reg[6].tt[k]);
        end

        pipe_next[8] = pipe_reg[7];
        qr = qmul_fin(pipe_reg[7].pp[0]);
        pipe_next[8].eh  = qr.val;
        pipe_next[8].flt = pipe_reg[7].flt | qr.flt;
        qr = qmul_fin(pipe_reg[7].pp[1]);
        pipe_next[8].v   = qr.val;
        pipe_next[8].flt = pipe_next[8].flt | qr.flt;
        for (int k = 0; k < 6; k++) begin
            qr = qmul_fin(pipe_reg[7].pp[k+2]);
            pipe_next[8].cp[k] = qr.val;
            pipe_next[8].flt   = pipe_next[8].flt | qr.flt;
        end

        pipe_next[9] = pipe_reg[8];
        pipe_next[9].pp[0] = qmul_pp(pipe_reg[8].eh, pipe_reg[8].s);
        for (int i = 0; i < 3; i++) begin
            pipe_next[9].pp[i+1] = qmul_pp(pipe_reg[8].v, pipe_reg[8].t[i]);
        end

        pipe_next[10] = pipe_reg[9];
        qr = qmul_fin(pipe_reg[9].pp[0]);
        pipe_next[10].eh  = qr.val;
        pipe_next[10].flt = pipe_reg[9].flt | qr.flt;
        for (int i = 0; i < 3; i++) begin
            qr = qmul_fin(pipe_reg[9].pp[i+1]);
            pipe_next[10].f[i] = qr.val;
            pipe_next[10].flt  = pipe_next[10].flt | qr.flt;
        end

        pipe_next[11] = pipe_reg[10];
        pipe_next[11].pp[0] = qmul_pp(pipe_reg[10].eh, pipe_reg[10].s);

        pipe_next[12] = pipe_reg[11];
        qr = qmul_fin(pipe_reg[11].pp[0]);
        pipe_next[12].eh  = qr.val;
        pipe_next[12].flt = pipe_reg[11].flt | qr.flt;

        pipe_next[13] = pipe_reg[12];
        pipe_next[13].pp[0] = qmul_pp(pipe_reg[12].eh, pipe_reg[12].rest);

        pipe_next[14] = pipe_reg[13];
        qr = qmul_fin(pipe_reg[13].pp[0]);
        pipe_next[14].eh  = qr.val;
        pipe_next[14].flt = pipe_reg[13].flt | qr.flt;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    always_comb begin
        o32_t  oc;
        item_t it;
        it           = pipe_reg[PIPE_STAGES-1];
        m_fault_next = it.flt;
        oc = clamp32(it.eh);
        m_data_next[31:0] = oc.val;
        m_fault_next      = m_fault_next | oc.flt;
        for (int i = 0; i < 3; i++) begin
            oc = clamp32(it.f[i]);
            m_data_next[32*(i+1) +: 32] = oc.val;
            m_fault_next                = m_fault_next | oc.flt;
        end
        for (int k = 0; k < 6; k++) begin
            oc = clamp32(it.cp[k]);
            m_data_next[32*(k+4) +: 32] = oc.val;
            m_fault_next                = m_fault_next | oc.flt;
        end
        if (it.zero) begin
            m_data_next  = '0;
            m_fault_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg  <= m_data_next;
            m_fault_reg <= m_fault_next;
        end
    end

endmodule

>>> hw/rtl/resf_checker.sv
// Port-level checker for the rod edge stretch force unit and its bind.
module resf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [resf_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic                           m_axis_tuser
);
    import resf_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output register state");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("stalled result dropped");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind rod_edge_stretch_force_unit resf_checker u_resf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/rod_edge_stretch_force_unit_check.sv
// Checker for the rod edge stretch force unit: predicts each result and compares it.
module rod_edge_stretch_force_unit_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [resf_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [resf_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [resf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            mismatch_count,
    output int                            pending_forces
);
    timeunit 1ns;
    timeprecision 1ps;
    import resf_pkg::*;

    typedef struct packed {
        logic [9:0][31:0] words;
        logic             fault;
    } force_result_t;

    localparam longint SAT_WIDE = 64'sh3FFF_FFFF_FFFF_FFFF;

    force_result_t expected_forces[$];
    logic [31:0]   elastic_mod;
    logic [31:0]   damping_mod;

    function automatic longint fx_mul(longint a, longint b, inout bit flt);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        longint       r;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p  = {64'b0, ma} * {64'b0, mb};
        p  = (p + 128'h8000) >> 16;
        if (p > 128'(SAT_WIDE)) begin
            p   = 128'(SAT_WIDE);
            flt = 1'b1;
        end
        r = p[63:0];
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint fx_div(longint n, longint d);
        longint q;
        q = ((n < 0 ? -n : n) + d / 2) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic logic [31:0] fx_out(longint a, inout bit flt);
        if (a > 64'sd2147483647) begin
            flt = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (a < -64'sd2147483648) begin
            flt = 1'b1;
            return 32'h8000_0000;
        end
        return a[31:0];
    endfunction

    function automatic force_result_t predict_force(logic [S_DATA_W-1:0] d, logic viscous);
        force_result_t res;
        longint        e[3];
        longint        t[3];
        longint        len, r0, r1, rest, md, ks, s, inv_len, inv_rest, dd, v, a;
        int            pi_idx[6];
        int            pj_idx[6];
        bit            flt;
        pi_idx = '{0, 0, 0, 1, 1, 2};
        pj_idx = '{0, 1, 2, 1, 2, 2};
        flt  = 1'b0;
        res  = '0;
        len  = d[126:96];
        r0   = d[157:127];
        r1   = d[188:158];
        rest = d[219:189];
        md   = viscous ? damping_mod : elastic_mod;
        if (len == 0 || rest == 0) begin
            res.fault = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            e[i] = longint'($signed(d[32*i +: 32]));
            t[i] = fx_div(e[i] * 65536, len);
        end
        ks       = fx_mul(md, 205887, flt);
        ks       = fx_mul(ks, r0, flt);
        ks       = fx_mul(ks, r1, flt);
        s        = fx_div(len << 16, rest) - 65536;
        inv_len  = fx_div(64'sd1 << 32, len);
        inv_rest = fx_div(64'sd1 << 32, rest);
        dd       = inv_rest - inv_len;
        v = fx_mul(ks, 32768, flt);
        v = fx_mul(v, s, flt);
        v = fx_mul(v, s, flt);
        v = fx_mul(v, rest, flt);
        res.words[0] = fx_out(v, flt);
        v = fx_mul(ks, s, flt);
        for (int i = 0; i < 3; i++) begin
            a = fx_mul(v, t[i], flt);
            res.words[1+i] = fx_out(a, flt);
        end
        for (int i = 0; i < 6; i++) begin
            a = fx_mul(t[pi_idx[i]], t[pj_idx[i]], flt);
            a = fx_mul(a, inv_len, flt);
            if (pi_idx[i] == pj_idx[i]) begin
                a = a + dd;
                if (a > SAT_WIDE) begin
                    a = SAT_WIDE;
                    flt = 1'b1;
                end else if (a < -SAT_WIDE) begin
                    a = -SAT_WIDE;
                    flt = 1'b1;
                end
            end
            a = fx_mul(ks, a, flt);
            res.words[4+i] = fx_out(a, flt);
        end
        res.fault = flt;
        return res;
    endfunction

    assign pending_forces = expected_forces.size();

    always @(posedge aclk) begin
        force_result_t want;
        if (!aresetn) begin
            elastic_mod <= 32'd65536;
            damping_mod <= 32'd0;
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_ELASTIC) elastic_mod <= cfg_data;
                else if (cfg_index == REG_DAMPING) damping_mod <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_forces = {expected_forces,
                                   predict_force(s_axis_tdata, s_axis_tuser)};
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_forces.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h fault %b", m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_forces.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        if (m_axis_tdata[32*i +: 32] !== want.words[i]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("word %0d: expected %h, got %h", i,
                                         want.words[i], m_axis_tdata[32*i +: 32]);
                        end
                    end
                    if (m_axis_tuser !== want.fault) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("range fault: expected %b, got %b", want.fault,
                                     m_axis_tuser);
                    end
                end
            end
        end
    end

endmodule

>>> test/rod_edge_stretch_force_unit_test.sv
// Top of the rod edge stretch force unit testbench: clock, reset, stimulus and verdict.
module rod_edge_stretch_force_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import resf_pkg::*;

    localparam int LATENCY = 70;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ELASTIC;
    logic [31:0]           cfg_data = '0;
    int                    mismatch_count;
    int                    pending_forces;
    int                    calm_left = 0;
    int                    stall_left = 0;
    bit                    sender_calm = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    rod_edge_stretch_force_unit DUT (.*);

    rod_edge_stretch_force_unit_check checker_i (.*);

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 255) == 0) calm_left = $urandom_range(50, 300);
            else if ($urandom_range(0, 99) < 12) stall_left = $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 2) stall_left = $urandom_range(15, 60);
        end
    end

    task automatic write_modulus(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_requests();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_forces != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic send_edge(logic signed [31:0] ex, logic signed [31:0] ey,
                             logic signed [31:0] ez, logic [30:0] len, logic [30:0] r0,
                             logic [30:0] r1, logic [30:0] rest, logic viscous);
        int r;
        int gap;
        @(negedge aclk);
        s_axis_tdata  <= {4'b0, rest, r1, r0, len, ez, ey, ex};
        s_axis_tuser  <= viscous;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        r = $urandom_range(0, 99);
        if (sender_calm || r < 55) gap = 0;
        else if (r < 88) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_random_edge();
        int          r;
        int          k;
        logic [31:0] c[3];
        real         sq;
        logic [30:0] len;
        logic [30:0] rest;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            k  = $urandom_range(0, 14);
            sq = 0.0;
            for (int i = 0; i < 3; i++) begin
                c[i] = $urandom_range(0, 1 << (k + 12));
                if ($urandom_range(0, 1)) c[i] = -c[i];
                sq += real'($signed(c[i])) * real'($signed(c[i]));
            end
            len = 31'($rtoi($sqrt(sq) + 0.5));
            if (len == 31'd0) len = 31'd1;
            if ($urandom_range(0, 9) == 0) len = 31'(len + $urandom_range(0, 255));
            rest = 31'(longint'(len) * $urandom_range(500, 1500) / 1000);
            if (rest == 31'd0) rest = 31'd1;
            send_edge(c[0], c[1], c[2], len,
                      31'($urandom_range(0, 1 << $urandom_range(8, 18))),
                      31'($urandom_range(0, 1 << $urandom_range(8, 18))), rest,
                      1'($urandom_range(0, 1)));
        end else if (r < 88) begin
            send_edge($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                      31'($urandom), 31'($urandom), 1'($urandom_range(0, 1)));
        end else begin
            len  = $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom);
            rest = $urandom_range(0, 3) == 0 ? 31'd0 : 31'($urandom_range(1, 1 << 20));
            send_edge($urandom, $urandom, $urandom, len, 31'($urandom_range(0, 65536)),
                      31'($urandom_range(0, 65536)), rest, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [31:0] elastic_set[5];
        logic [31:0] damping_set[5];
        elastic_set = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd3 << 16, 32'd0};
        damping_set = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1 << 14, 32'd0};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed corners at the reset moduli.
        send_edge(32'sd65536, 0, 0, 31'd65536, 31'd65536, 31'd65536, 31'd65536, 1'b0);
        send_edge(32'sd131072, 0, 0, 31'd131072, 31'd65536, 31'd65536, 31'd65536, 1'b0);
        send_edge(0, -32'sd196608, 0, 31'd196608, 31'd32768, 31'd65536, 31'd262144, 1'b0);
        send_edge(0, 0, 32'sd65536, 31'd0, 31'd65536, 31'd65536, 31'd65536, 1'b0);
        send_edge(32'sd65536, 0, 0, 31'd65536, 31'd65536, 31'd65536, 31'd0, 1'b0);
        send_edge(0, 0, 0, 31'd0, 31'd0, 31'd0, 31'd0, 1'b1);
        send_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 1'b0);
        send_edge(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
        send_edge(32'h7FFF_FFFF, 32'h8000_0000, 32'sd1, 31'h7FFF_FFFF, 31'd1, 31'd1,
                  31'h7FFF_FFFF, 1'b1);
        send_edge(32'sd1, -32'sd1, 32'sd1, 31'd1, 31'd65536, 31'd65536, 31'd1, 1'b0);
        send_edge(32'sd39321, 32'sd52428, 0, 31'd65536, 31'd6553, 31'd3276, 31'd60000, 1'b0);
        send_edge(32'sd39321, 32'sd52428, 0, 31'd65536, 31'd6553, 31'd3276, 31'd60000, 1'b1);
        send_edge(-32'sd1000000, 32'sd2000000, -32'sd500000, 31'd2291287, 31'd100000,
                  31'd200000, 31'd2000000, 1'b0);

        for (int phase = 0; phase < 5; phase++) begin
            drain_requests();
            write_modulus(REG_ELASTIC, phase == 4 ? $urandom : elastic_set[phase]);
            write_modulus(REG_DAMPING, phase == 4 ? $urandom : damping_set[phase]);
            sender_calm = (phase == 2);
            send_edge(32'sd65536, 32'sd65536, 0, 31'd92682, 31'd65536, 31'd65536, 31'd65536,
                      1'b0);
            send_edge(32'sd65536, 32'sd65536, 0, 31'd92682, 31'd65536, 31'd65536, 31'd65536,
                      1'b1);
            for (int n = 0; n < 140; n++) send_random_edge();
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        drain_requests();
        if (mismatch_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/resf_pkg.sv
hw/rtl/resf_divider.sv
hw/rtl/rod_edge_stretch_force_unit.sv
hw/rtl/resf_checker.sv
test/rod_edge_stretch_force_unit_check.sv
test/rod_edge_stretch_force_unit_test.sv
